[hdl/u16u8_pkg.sv]
package u16u8_pkg;

   // one transcoded request: up to six utf-8 bytes, first byte at index 0
   localparam int MaxBytes = 6;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     last;
   } u16u8_job_type;

   // encoding of one 16-bit value as 1, 2 or 3 bytes
   typedef struct packed {
      logic [2:0][7:0] b;
      logic [1:0]      len;
   } u16u8_enc_type;

   localparam logic [15:0] HighFirst = 16'hD800;
   localparam logic [15:0] HighLast  = 16'hDBFF;
   localparam logic [15:0] LowFirst  = 16'hDC00;
   localparam logic [15:0] LowLast   = 16'hDFFF;
   localparam logic [20:0] PlaneBase = 21'h10000;

   function automatic u16u8_enc_type enc_unit(input logic [15:0] c);
      u16u8_enc_type r;
      r = '0;
      if (c < 16'h0080) begin
         r.b[0] = c[7:0];
         r.len  = 2'd1;
      end else if (c < 16'h0800) begin
         r.b[0] = {3'b110, c[10:6]};
         r.b[1] = {2'b10, c[5:0]};
         r.len  = 2'd2;
      end else begin
         r.b[0] = {4'b1110, c[15:12]};
         r.b[1] = {2'b10, c[11:6]};
         r.b[2] = {2'b10, c[5:0]};
         r.len  = 2'd3;
      end
      return r;
   endfunction

endpackage

[hdl/u16u8_front.sv]
module u16u8_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [15:0]              req_code_unit,
   input  logic                     req_last_unit,
   input  logic                     q_full,
   output logic                     push,
   output u16u8_pkg::u16u8_job_type push_job
);
   import u16u8_pkg::*;

   logic          held_valid_ff, held_valid_in;
   logic [9:0]    held_bits_ff, held_bits_in;
   logic          accept;
   logic          is_high, is_low;
   logic [20:0]   cp;
   u16u8_enc_type held_enc, unit_enc;
   u16u8_job_type job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      is_high   = req_code_unit inside {[HighFirst:HighLast]};
      is_low    = req_code_unit inside {[LowFirst:LowLast]};
      cp        = PlaneBase + {1'b0, held_bits_ff, req_code_unit[9:0]};
      held_enc  = enc_unit({6'b110110, held_bits_ff});
      unit_enc  = enc_unit(req_code_unit);
      job       = '0;
      job.last  = req_last_unit;
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         held_valid_in = 1'b0;
         if (held_valid_ff && is_low) begin
            // surrogate pair: one 4-byte sequence
            job.bytes[0] = {5'b11110, cp[20:18]};
            job.bytes[1] = {2'b10, cp[17:12]};
            job.bytes[2] = {2'b10, cp[11:6]};
            job.bytes[3] = {2'b10, cp[5:0]};
            job.count    = 3'd4;
         end else begin
            // flush a held high surrogate as 3 bytes
            if (held_valid_ff) begin
               job.bytes[0] = held_enc.b[0];
               job.bytes[1] = held_enc.b[1];
               job.bytes[2] = held_enc.b[2];
               job.count    = 3'd3;
            end
            if (is_high && !req_last_unit) begin
               held_valid_in = 1'b1;
               held_bits_in  = req_code_unit[9:0];
            end else if (held_valid_ff) begin
               job.bytes[3] = unit_enc.b[0];
               job.bytes[4] = unit_enc.b[1];
               job.bytes[5] = unit_enc.b[2];
               job.count    = 3'd3 + {1'b0, unit_enc.len};
            end else begin
               job.bytes[0] = unit_enc.b[0];
               job.bytes[1] = unit_enc.b[1];
               job.bytes[2] = unit_enc.b[2];
               job.count    = {1'b0, unit_enc.len};
            end
         end
      end
   end

   assign push     = accept && (job.count != 3'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
      held_bits_ff <= held_bits_in;
   end

endmodule

[hdl/u16u8_queue.sv]
module u16u8_queue #(
   parameter int QDEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  u16u8_pkg::u16u8_job_type push_job,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output u16u8_pkg::u16u8_job_type head_job
);
   import u16u8_pkg::*;

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   u16u8_job_type store_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full       = count_ff == CW'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = store_ff[rd_ptr_ff];

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[hdl/u16u8_back.sv]
module u16u8_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  u16u8_pkg::u16u8_job_type head_job,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_end,
   output logic                     rsp_string_end
);
   import u16u8_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_end_ff, str_end_ff;
   logic       load, is_last;

   always_comb begin
      load     = head_valid && (!valid_ff || !rsp_stall);
      is_last  = (idx_ff + 3'd1) == head_job.count;
      pop      = load && is_last;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         byte_ff    <= head_job.bytes[idx_ff];
         run_end_ff <= is_last;
         str_end_ff <= is_last && head_job.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_string_end = str_end_ff;

endmodule

[hdl/utf16_to_utf8_transcoder_core.sv]
// the first utf-8 byte of a request passes through the job queue and then the output register
// throughput: one request per cycle while the job queue has room; the byte
//    emitter sends one byte per cycle while rsp_stall is low
// a held high surrogate yields no job of its own
// reset (synchronous, active high) drops any held surrogate and empties the queue
module utf16_to_utf8_transcoder_core #(
   parameter int QDEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic        rsp_string_end
);
   import u16u8_pkg::*;

   // front to queue
   logic          push;
   u16u8_job_type push_job;
   logic          q_full;

   // queue to back
   logic          head_valid;
   u16u8_job_type head_job;
   logic          pop;

   // front: classifies the code unit, pairs surrogates, builds the byte job
   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job)
   );

   // short job queue decouples request intake from byte emission
   u16u8_queue #(
      .QDEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: walks the head job one byte per cycle, while not stalled, into the output register
   u16u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   // a string end always closes the run of its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string_end without run_end");

   // every queued job carries between one and six bytes
   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.count != 3'd0) && (push_job.count <= 3'd6))
      else $error("job byte count out of range");

   // the front never writes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");

   // the back only pops a job that is present
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import u16u8_pkg::*;

   // one utf-16 request as driven on the input channel
   typedef struct {
      logic [15:0] unit;
      logic        last;
   } utf16_unit_type;

   // one utf-8 byte as seen on the result channel
   typedef struct {
      logic [7:0] b;
      logic       run_end;
      logic       string_end;
   } utf8_byte_type;

   localparam int HoldLen     = 200;   // cycles of the long receiver hold-off
   localparam int PhaseItems  = 50;    // at least this many random requests per phase
   localparam int NumPhases   = 5;
   localparam int DrainCycles = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit = '0;
   logic        req_last_unit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_end;
   logic        rsp_string_end;

   // requests waiting to be driven, bytes still owed by the block
   utf16_unit_type units_to_send[$];
   utf8_byte_type  utf8_due[$];
   logic [7:0]     run_bytes[$];

   // own copy of the surrogate holding state
   logic        pending_high = 1'b0;
   logic [9:0]  pending_bits = '0;

   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        pressure_on = 1'b0;
   int          hold_cycles = 0;
   logic        hold_active = 1'b0;

   utf16_to_utf8_transcoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_unit  (req_code_unit),
      .req_last_unit  (req_last_unit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one byte onto the tail of run_bytes
   function automatic void append_byte(input logic [7:0] b);
      run_bytes.insert(run_bytes.size(), b);
   endfunction

   // utf-8 encoding of one scalar value, appended to run_bytes
   function automatic void append_scalar(input logic [20:0] cp);
      if (cp < 21'h80) begin
         append_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         append_byte({3'b110, cp[10:6]});
         append_byte({2'b10, cp[5:0]});
      end else if (cp < PlaneBase) begin
         append_byte({4'b1110, cp[15:12]});
         append_byte({2'b10, cp[11:6]});
         append_byte({2'b10, cp[5:0]});
      end else begin
         append_byte({5'b11110, cp[20:18]});
         append_byte({2'b10, cp[17:12]});
         append_byte({2'b10, cp[11:6]});
         append_byte({2'b10, cp[5:0]});
      end
   endfunction

   // expected bytes for one accepted request, queued in utf8_due
   function automatic void transcode_unit(input logic [15:0] c, input logic last);
      logic          is_high;
      logic          is_low;
      logic          paired;
      utf8_byte_type e;
      is_high = (c >= HighFirst) && (c <= HighLast);
      is_low  = (c >= LowFirst) && (c <= LowLast);
      paired  = 1'b0;
      run_bytes.delete();
      if (pending_high) begin
         pending_high = 1'b0;
         if (is_low) begin
            // surrogate pair folds into one supplementary code point
            append_scalar(PlaneBase + {1'b0, pending_bits, c[9:0]});
            paired = 1'b1;
         end else begin
            // held high surrogate flushed as its own 3-byte form
            append_scalar({5'd0, HighFirst[15:10], pending_bits});
         end
      end
      if (!paired) begin
         if (is_high && !last) begin
            pending_high = 1'b1;
            pending_bits = c[9:0];
         end else begin
            append_scalar({5'd0, c});
         end
      end
      foreach (run_bytes[i]) begin
         e.b          = run_bytes[i];
         e.run_end    = (i == run_bytes.size() - 1);
         e.string_end = e.run_end && last;
         utf8_due.insert(utf8_due.size(), e);
      end
   endfunction

   task automatic queue_unit(input logic [15:0] unit, input logic last);
      utf16_unit_type u;
      u.unit = unit;
      u.last = last;
      units_to_send.insert(units_to_send.size(), u);
   endtask

   // random strings: mostly well-formed text, some lone surrogates and noise
   task automatic add_random_strings(input int target);
      int          added;
      int          len;
      int          kind;
      logic        lastf;
      logic [15:0] u;
      added = 0;
      while (added < target) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            kind  = $urandom_range(0, 99);
            lastf = (i == len - 1);
            if (kind < 20) begin
               u = 16'($urandom_range(16'h0000, 16'h007F));
            end else if (kind < 35) begin
               u = 16'($urandom_range(16'h0080, 16'h07FF));
            end else if (kind < 55) begin
               if ($urandom_range(0, 1))
                  u = 16'($urandom_range(16'h0800, 16'hD7FF));
               else
                  u = 16'($urandom_range(16'hE000, 16'hFFFF));
            end else if (kind < 80) begin
               // well-formed pair: the high half is never the last request
               queue_unit(16'($urandom_range(HighFirst, HighLast)), 1'b0);
               added++;
               u = 16'($urandom_range(LowFirst, LowLast));
            end else if (kind < 85) begin
               u = 16'($urandom_range(HighFirst, HighLast));
            end else if (kind < 90) begin
               u = 16'($urandom_range(LowFirst, LowLast));
            end else begin
               u = 16'($urandom_range(0, 16'hFFFF));
            end
            queue_unit(u, lastf);
            added++;
         end
      end
   endtask

   // driver: predicts on acceptance, holds the payload while stalled
   always @(posedge clock) begin : drive_proc
      utf16_unit_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            transcode_unit(req_code_unit, req_last_unit);
         end
         // a new request may only be offered once the current one is gone
         if (!req_valid || !req_stall) begin
            if (units_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = units_to_send.pop_front();
               req_valid     <= 1'b1;
               req_code_unit <= nxt.unit;
               req_last_unit <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted once during the pressure phase
   always @(posedge clock) begin : holdoff_proc
      if (reset) begin
         hold_cycles <= 0;
         hold_active <= 1'b0;
      end else if (pressure_on && hold_cycles < HoldLen) begin
         hold_cycles <= hold_cycles + 1;
         hold_active <= 1'b1;
      end else begin
         hold_active <= 1'b0;
      end
   end

   // monitor: every accepted byte is checked against the oldest expectation
   always @(posedge clock) begin : check_proc
      utf8_byte_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (utf8_due.size() == 0) begin
               $display("%0t: unexpected byte %h run_end %b string_end %b",
                        $time, rsp_out_byte, rsp_run_end, rsp_string_end);
               mismatches++;
            end else begin
               want = utf8_due.pop_front();
               if (rsp_out_byte !== want.b || rsp_run_end !== want.run_end ||
                   rsp_string_end !== want.string_end) begin
                  $display("%0t: expected byte %h run_end %b string_end %b, got %h %b %b",
                           $time, want.b, want.run_end, want.string_end,
                           rsp_out_byte, rsp_run_end, rsp_string_end);
                  mismatches++;
               end
            end
         end
         rsp_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // phases: no idling, sender idle, receiver stalling, both, long hold-off
   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NumPhases; p++) begin
         @(negedge clock);
         send_idle_pct  = (p == 1) ? 69 : (p == 3) ? 29 : 0;
         recv_stall_pct = (p == 2) ? 69 : (p == 3) ? 29 : 0;
         pressure_on    = (p == NumPhases - 1);
         if (p == 0) begin
            // unit zero as a whole string, then the encoding length edges
            queue_unit(16'h0000, 1'b1);
            queue_unit(16'h007F, 1'b0);
            queue_unit(16'h0080, 1'b0);
            queue_unit(16'h07FF, 1'b0);
            queue_unit(16'h0800, 1'b0);
            queue_unit(16'hD7FF, 1'b0);
            queue_unit(16'hE000, 1'b0);
            queue_unit(16'hFFFF, 1'b1);
            // lowest and highest surrogate pairs
            queue_unit(HighFirst, 1'b0);
            queue_unit(LowFirst, 1'b0);
            queue_unit(HighLast, 1'b0);
            queue_unit(LowLast, 1'b1);
            // lone low as last, high surrogate as last unit
            queue_unit(LowFirst, 1'b1);
            queue_unit(HighFirst, 1'b1);
            // held high followed by another high, which then pairs
            queue_unit(16'hD801, 1'b0);
            queue_unit(16'hDA00, 1'b0);
            queue_unit(16'hDC05, 1'b0);
            // held high followed by ascii
            queue_unit(16'hDB00, 1'b0);
            queue_unit(16'h0041, 1'b0);
            // held high followed by a high that ends the string: six bytes
            queue_unit(16'hD900, 1'b0);
            queue_unit(16'hD9FF, 1'b1);
            // pair closing a string
            queue_unit(16'hDAAA, 1'b0);
            queue_unit(LowLast, 1'b1);
            // held high followed by 2-byte and 3-byte units
            queue_unit(16'hD8C3, 1'b0);
            queue_unit(16'h07FF, 1'b1);
            queue_unit(HighLast, 1'b0);
            queue_unit(16'hFFFF, 1'b1);
         end
         add_random_strings(PhaseItems);
         // phase ends once every request is in and every byte is out
         while (units_to_send.size() != 0 || req_valid || utf8_due.size() != 0)
            @(negedge clock);
      end
      // let any stray bytes show up before the verdict
      repeat (DrainCycles) @(negedge clock);
      if (mismatches == 0 && utf8_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
